// ----- sv/dcpv_pkg.sv -----
// ----------------------------------------------------------------------------
// dcpv_pkg: shared types and constants for the dominant color pixel vote
// Holds the color codes, the register indexes, the reset values and the
// reciprocal that divides a vote count by the scale factor.
// ----------------------------------------------------------------------------
`default_nettype none

package dcpv_pkg;

	localparam int unsigned COUNT_WIDTH_DEF = 21;
	localparam int unsigned CHAN_W          = 8;
	localparam int unsigned CFG_INDEX_W     = 2;

	localparam logic [CHAN_W-1:0] CHROMA_RESET = 8'd50;
	localparam logic [CHAN_W-1:0] LEVEL_RESET  = 8'd120;

	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every 32-bit x.
	localparam logic [31:0] RECIP_100   = 32'h51EB_851F;
	localparam int unsigned RECIP_SHIFT = 37;

	typedef enum logic [1:0] {
		COLOR_NONE  = 2'd0,
		COLOR_RED   = 2'd1,
		COLOR_GREEN = 2'd2,
		COLOR_BLUE  = 2'd3
	} color_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CHROMA = 2'd0,
		CFG_LEVEL  = 2'd1
	} cfg_index_t;

	typedef struct packed {
		logic red;
		logic green;
		logic blue;
	} vote_t;

	typedef struct packed {
		logic en;
		logic valid;
		logic last;
	} stage_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/dominant_color_pixel_vote.sv -----
// ----------------------------------------------------------------------------
// dominant_color_pixel_vote: per-frame dominant color from pixel votes
// Votes each pixel for its clearly dominant channel and reports, at the end
// of each frame, which color led by a strict margin after scaling by 100.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Content
// s_*       in         one pixel request; tlast marks the frame's last pixel
// m_*       out        one color code request per frame
// cfg_*     in         threshold register writes, always ready
//
// A pixel request is taken every cycle while the output register is empty
// or being drained. A frame's color is offered once its last pixel has
// passed the input register, the counters, the reciprocal multiply and
// the output register.
// When m_tready is low with a result held, the whole pipeline holds.
// Reset clears the counters and sets both thresholds to their defaults.
`default_nettype none

module dominant_color_pixel_vote #(
	parameter int unsigned COUNT_WIDTH = dcpv_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [23:0]                          s_tdata,  // red, green, blue
	input  wire logic                                 s_tlast,  // frame_end
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [7:0]                                m_tdata,  // color_code, zeros
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [dcpv_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [dcpv_pkg::CHAN_W-1:0]          cfg_data
);
	import dcpv_pkg::*;

	logic                   en;
	logic [CHAN_W-1:0]      chroma_threshold_q;
	logic [CHAN_W-1:0]      level_threshold_q;
	logic                   valid_s1;
	logic                   last_s1;
	logic [CHAN_W-1:0]      red_s1;
	logic [CHAN_W-1:0]      green_s1;
	logic [CHAN_W-1:0]      blue_s1;
	vote_t                  vote;
	stage_ctrl_t            tally_ctrl;
	logic                   valid_s2;
	logic [COUNT_WIDTH-1:0] red_s2;
	logic [COUNT_WIDTH-1:0] green_s2;
	logic [COUNT_WIDTH-1:0] blue_s2;
	logic                   valid_s3;
	color_t                 color;
	color_t                 color_q;

	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_threshold_q <= CHROMA_RESET;
			level_threshold_q  <= LEVEL_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_CHROMA: begin
					chroma_threshold_q <= cfg_data;
				end
				CFG_LEVEL: begin
					level_threshold_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
			m_tvalid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s1   <= s_tdata[7:0];
			green_s1 <= s_tdata[15:8];
			blue_s1  <= s_tdata[23:16];
			last_s1  <= s_tlast;
			color_q  <= color;
		end
	end

	dcpv_classify u_classify (
		.red              (red_s1),
		.green            (green_s1),
		.blue             (blue_s1),
		.chroma_threshold (chroma_threshold_q),
		.level_threshold  (level_threshold_q),
		.vote             (vote)
	);

	assign tally_ctrl.en    = en;
	assign tally_ctrl.valid = valid_s1;
	assign tally_ctrl.last  = last_s1;

	dcpv_tally #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_tally (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (tally_ctrl),
		.vote     (vote),
		.valid_s2 (valid_s2),
		.red_s2   (red_s2),
		.green_s2 (green_s2),
		.blue_s2  (blue_s2)
	);

	dcpv_decide #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.red_s2   (red_s2),
		.green_s2 (green_s2),
		.blue_s2  (blue_s2),
		.valid_s3 (valid_s3),
		.color    (color)
	);

	assign m_tdata = {6'b0, color_q};

endmodule

`default_nettype wire

// ----- sv/dcpv_classify.sv -----
// ----------------------------------------------------------------------------
// dcpv_classify: per-pixel vote decision
// Checks the chroma of one pixel against its threshold and picks the channel
// that is strictly largest and above the level threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpv_classify (
	input  wire logic [dcpv_pkg::CHAN_W-1:0] red,
	input  wire logic [dcpv_pkg::CHAN_W-1:0] green,
	input  wire logic [dcpv_pkg::CHAN_W-1:0] blue,
	input  wire logic [dcpv_pkg::CHAN_W-1:0] chroma_threshold,
	input  wire logic [dcpv_pkg::CHAN_W-1:0] level_threshold,
	output dcpv_pkg::vote_t                  vote
);
	import dcpv_pkg::*;

	logic [CHAN_W-1:0] max_val;
	logic [CHAN_W-1:0] min_val;
	logic [CHAN_W-1:0] chroma;
	logic              colorful;

	always_comb begin
		max_val = (red > green) ? red : green;
		if (blue > max_val) begin
			max_val = blue;
		end
		min_val = (red < green) ? red : green;
		if (blue < min_val) begin
			min_val = blue;
		end
	end

	assign chroma   = max_val - min_val;
	assign colorful = chroma > chroma_threshold;

	assign vote.red   = colorful && (red > green) && (red > blue) && (red > level_threshold);
	assign vote.green = colorful && (green > red) && (green > blue)
		&& (green > level_threshold);
	assign vote.blue  = colorful && (blue > green) && (blue > red)
		&& (blue > level_threshold);

endmodule

`default_nettype wire

// ----- sv/dcpv_tally.sv -----
// ----------------------------------------------------------------------------
// dcpv_tally: saturating vote counters
// Counts the votes of a frame and, on its last pixel, hands the final counts
// to the next stage and clears the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpv_tally #(
	parameter int unsigned COUNT_WIDTH = dcpv_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dcpv_pkg::stage_ctrl_t  ctrl,
	input  wire dcpv_pkg::vote_t        vote,
	output logic                        valid_s2,
	output logic [COUNT_WIDTH-1:0]      red_s2,
	output logic [COUNT_WIDTH-1:0]      green_s2,
	output logic [COUNT_WIDTH-1:0]      blue_s2
);
	import dcpv_pkg::*;

	logic [COUNT_WIDTH-1:0] red_q;
	logic [COUNT_WIDTH-1:0] green_q;
	logic [COUNT_WIDTH-1:0] blue_q;
	logic [COUNT_WIDTH-1:0] red_next;
	logic [COUNT_WIDTH-1:0] green_next;
	logic [COUNT_WIDTH-1:0] blue_next;

	function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] count,
		input logic hit);
		bump = (hit && (count != '1)) ? count + 1'b1 : count;
	endfunction

	assign red_next   = bump(red_q, vote.red);
	assign green_next = bump(green_q, vote.green);
	assign blue_next  = bump(blue_q, vote.blue);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q    <= '0;
			green_q  <= '0;
			blue_q   <= '0;
			valid_s2 <= 1'b0;
		end else if (ctrl.en) begin
			valid_s2 <= ctrl.valid && ctrl.last;
			if (ctrl.valid) begin
				if (ctrl.last) begin
					red_q   <= '0;
					green_q <= '0;
					blue_q  <= '0;
				end else begin
					red_q   <= red_next;
					green_q <= green_next;
					blue_q  <= blue_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			red_s2   <= red_next;
			green_s2 <= green_next;
			blue_s2  <= blue_next;
		end
	end

endmodule

`default_nettype wire

// ----- sv/dcpv_decide.sv -----
// ----------------------------------------------------------------------------
// dcpv_decide: frame decision
// Scales the three final counts down by one hundred through a reciprocal
// multiply, registers the quotients and picks the strictly leading color.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpv_decide #(
	parameter int unsigned COUNT_WIDTH = dcpv_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   valid_s2,
	input  wire logic [COUNT_WIDTH-1:0] red_s2,
	input  wire logic [COUNT_WIDTH-1:0] green_s2,
	input  wire logic [COUNT_WIDTH-1:0] blue_s2,
	output logic                        valid_s3,
	output dcpv_pkg::color_t            color
);
	import dcpv_pkg::*;

	localparam int unsigned QUOT_W = COUNT_WIDTH - 6;

	logic [63:0]       red_prod;
	logic [63:0]       green_prod;
	logic [63:0]       blue_prod;
	logic [QUOT_W-1:0] red_s3;
	logic [QUOT_W-1:0] green_s3;
	logic [QUOT_W-1:0] blue_s3;

	assign red_prod   = 64'(red_s2) * 64'(RECIP_100);
	assign green_prod = 64'(green_s2) * 64'(RECIP_100);
	assign blue_prod  = 64'(blue_s2) * 64'(RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_s3   <= red_prod[RECIP_SHIFT +: QUOT_W];
			green_s3 <= green_prod[RECIP_SHIFT +: QUOT_W];
			blue_s3  <= blue_prod[RECIP_SHIFT +: QUOT_W];
		end
	end

	always_comb begin
		color = COLOR_NONE;
		if ((red_s3 > green_s3) && (red_s3 > blue_s3)) begin
			color = COLOR_RED;
		end else if ((green_s3 > red_s3) && (green_s3 > blue_s3)) begin
			color = COLOR_GREEN;
		end else if ((blue_s3 > red_s3) && (blue_s3 > green_s3)) begin
			color = COLOR_BLUE;
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb_dominant_color_pixel_vote.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dominant_color_pixel_vote: self-checking bench for the pixel vote block
// Streams frames of pixel requests with mixed length and color balance. A
// local vote tally predicts each frame's color, and every color request that
// leaves the block is checked against it. The thresholds move between phases,
// and one frame gives red more votes than green that scale to a tie.
// ---------------------------------------------------------------------------
module tb_dominant_color_pixel_vote;
	import dcpv_pkg::*;

	localparam int unsigned VOTE_W        = COUNT_WIDTH_DEF;
	localparam int unsigned VOTE_SCALE    = 100;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT   = 1_500_000;
	localparam int unsigned PIXEL_TARGET  = 900;
	localparam int unsigned FRAME_TARGET  = 12;
	localparam int unsigned MAX_REPORTS   = 50;
	localparam int unsigned TIE_RED_RUN   = 120;
	localparam int unsigned TIE_GREEN_RUN = 101;
	localparam int unsigned PROBE_N       = 17;

	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last;
	} pixel_t;

	typedef struct packed {
		pixel_t px;
		logic   pinned;
		color_t want;
	} probe_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [23:0]            s_tdata   = '0;
	logic                   s_tlast   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [7:0]             m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CHAN_W-1:0]      cfg_data  = '0;

	logic [CHAN_W-1:0] chroma_thr  = CHROMA_RESET;
	logic [CHAN_W-1:0] level_thr   = LEVEL_RESET;
	logic [VOTE_W-1:0] red_tally   = '0;
	logic [VOTE_W-1:0] green_tally = '0;
	logic [VOTE_W-1:0] blue_tally  = '0;
	color_t            color_due[$];

	int unsigned pixels_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned burst_left  = 0;
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	rx_mode_t    rx_mode     = RX_OPEN;
	int unsigned rx_left     = 0;

	probe_t probe_rows [PROBE_N] = '{
		'{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, COLOR_NONE},
		'{'{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, COLOR_NONE},
		'{'{8'd255, 8'd0,   8'd0,   1'b1}, 1'b1, COLOR_NONE},
		'{'{8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd0,   8'd0,   8'd255, 1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd171, 8'd121, 8'd121, 1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd172, 8'd121, 8'd121, 1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd120, 8'd0,   8'd0,   1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd121, 8'd0,   8'd0,   1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd100, 8'd49,  8'd49,  1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd200, 8'd200, 8'd0,   1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd0,   8'd200, 8'd200, 1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd200, 8'd0,   8'd200, 1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd255, 8'd254, 8'd0,   1'b0}, 1'b0, COLOR_NONE},
		'{'{8'h55,  8'hAA,  8'h0F,  1'b0}, 1'b0, COLOR_NONE},
		'{'{8'hAA,  8'h55,  8'hF0,  1'b0}, 1'b0, COLOR_NONE},
		'{'{8'd0,   8'd0,   8'd0,   1'b1}, 1'b1, COLOR_NONE}
	};

	dominant_color_pixel_vote #(
		.COUNT_WIDTH(VOTE_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [VOTE_W-1:0] bump_tally(input logic [VOTE_W-1:0] n);
		return (&n) ? n : n + VOTE_W'(1);
	endfunction

	function automatic pixel_t make_pixel(input color_t hue, input logic bold);
		pixel_t            px;
		logic [CHAN_W-1:0] top;
		logic [CHAN_W-1:0] cap;
		px.red   = CHAN_W'($urandom);
		px.green = CHAN_W'($urandom);
		px.blue  = CHAN_W'($urandom);
		px.last  = 1'b0;
		if (hue != COLOR_NONE) begin
			top = bold ? CHAN_W'($urandom_range(200, 255)) : CHAN_W'($urandom_range(90, 255));
			if (bold) begin
				cap = 8'd100;
			end else begin
				cap = ($urandom_range(0, 3) == 0) ? top : top >> 1;
			end
			px.red   = CHAN_W'($urandom_range(0, cap));
			px.green = CHAN_W'($urandom_range(0, cap));
			px.blue  = CHAN_W'($urandom_range(0, cap));
			case (hue)
				COLOR_RED: begin
					px.red = top;
				end
				COLOR_GREEN: begin
					px.green = top;
				end
				default: begin
					px.blue = top;
				end
			endcase
		end
		return px;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < MAX_REPORTS) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	// Sends one pixel request, tallies its vote once it is taken and queues the
	// frame color on the last pixel. Bursts end in a gap with junk on the bus.
	task automatic push_pixel(input pixel_t px, input logic pinned, input color_t want);
		logic [CHAN_W-1:0] hi;
		logic [CHAN_W-1:0] lo;
		int unsigned       rs;
		int unsigned       gs;
		int unsigned       bs;
		color_t            code;
		int unsigned       gap;
		s_tdata  <= {px.blue, px.green, px.red};
		s_tlast  <= px.last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		hi = (px.red > px.green) ? px.red : px.green;
		hi = (hi > px.blue) ? hi : px.blue;
		lo = (px.red < px.green) ? px.red : px.green;
		lo = (lo < px.blue) ? lo : px.blue;
		if (hi - lo > chroma_thr) begin
			if (px.red > px.green && px.red > px.blue && px.red > level_thr) begin
				red_tally = bump_tally(red_tally);
			end
			if (px.green > px.red && px.green > px.blue && px.green > level_thr) begin
				green_tally = bump_tally(green_tally);
			end
			if (px.blue > px.red && px.blue > px.green && px.blue > level_thr) begin
				blue_tally = bump_tally(blue_tally);
			end
		end
		if (px.last) begin
			rs = 32'(red_tally) / VOTE_SCALE;
			gs = 32'(green_tally) / VOTE_SCALE;
			bs = 32'(blue_tally) / VOTE_SCALE;
			code = COLOR_NONE;
			if (rs > gs && rs > bs) begin
				code = COLOR_RED;
			end else if (gs > rs && gs > bs) begin
				code = COLOR_GREEN;
			end else if (bs > rs && bs > gs) begin
				code = COLOR_BLUE;
			end
			red_tally   = '0;
			green_tally = '0;
			blue_tally  = '0;
			frames_sent++;
			color_due.push_back(pinned ? want : code);
		end
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 3) : $urandom_range(4, 12);
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);
			s_tlast  <= 1'($urandom);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
	endtask

	// Holds the sender off until every pending frame color has come back and
	// the pipeline has emptied.
	task automatic settle();
		s_tvalid <= 1'b0;
		s_tdata  <= 24'($urandom);
		s_tlast  <= 1'($urandom);
		while (color_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CHAN_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_CHROMA) begin
			chroma_thr = val;
		end else if (idx == CFG_LEVEL) begin
			level_thr = val;
		end
	endtask

	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(20, 300);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN: begin
				m_tready <= 1'b1;
			end
			RX_COIN: begin
				m_tready <= 1'($urandom);
			end
			RX_SPARSE: begin
				m_tready <= ($urandom_range(0, 7) == 0);
			end
			default: begin
				m_tready <= ~m_tready;
			end
		endcase
	end

	always @(posedge clk) begin : color_check
		color_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (color_due.size() == 0) begin
				report_mismatch($sformatf("color %0d with no frame pending", m_tdata[1:0]));
			end else begin
				want = color_due.pop_front();
				if (m_tdata[1:0] !== want) begin
					report_mismatch($sformatf("color %0d, expected %0d", m_tdata[1:0], want));
				end
				if (m_tdata[7:2] !== '0) begin
					report_mismatch($sformatf("padding bits %b not zero", m_tdata[7:2]));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_dominant_color_pixel_vote: FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned       phase;
		int unsigned       frames;
		int unsigned       len;
		int unsigned       split;
		int unsigned       pixels_base;
		int unsigned       frames_base;
		logic [CHAN_W-1:0] chroma_val;
		logic [CHAN_W-1:0] level_val;
		color_t            fav;
		color_t            alt;
		color_t            hue;
		pixel_t            px;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_N; i++) begin
			push_pixel(probe_rows[i].px, probe_rows[i].pinned, probe_rows[i].want);
		end

		pixels_base = pixels_sent;
		frames_base = frames_sent;
		phase = 0;
		while (pixels_sent - pixels_base < PIXEL_TARGET
			|| frames_sent - frames_base < FRAME_TARGET) begin
			settle();
			case (phase)
				0: begin
					chroma_val = 8'd0;
					level_val  = 8'd0;
				end
				1: begin
					chroma_val = 8'd255;
					level_val  = 8'd255;
				end
				2: begin
					chroma_val = 8'd0;
					level_val  = 8'd255;
				end
				3: begin
					chroma_val = 8'd255;
					level_val  = 8'd0;
				end
				4: begin
					chroma_val = CHROMA_RESET;
					level_val  = LEVEL_RESET;
				end
				default: begin
					chroma_val = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom)
						: CHAN_W'($urandom_range(0, 120));
					level_val = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom)
						: CHAN_W'($urandom_range(0, 220));
				end
			endcase
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_CHROMA, chroma_val);
				write_reg(CFG_LEVEL, level_val);
			end else begin
				write_reg(CFG_LEVEL, level_val);
				write_reg(CFG_CHROMA, chroma_val);
			end
			write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
				CHAN_W'($urandom));
			cfg_valid <= 1'b0;

			// Red gets more votes than green, but both scale down to the same
			// count, so the frame ties.
			if (phase == 4) begin
				for (int unsigned i = 0; i < TIE_RED_RUN; i++) begin
					push_pixel(make_pixel(COLOR_RED, 1'b1), 1'b0, COLOR_NONE);
				end
				for (int unsigned i = 0; i < TIE_GREEN_RUN; i++) begin
					px = make_pixel(COLOR_GREEN, 1'b1);
					px.last = (i == TIE_GREEN_RUN - 1);
					push_pixel(px, 1'b0, COLOR_NONE);
				end
			end

			frames = (phase < 4) ? 2 : $urandom_range(3, 6);
			repeat (frames) begin
				len = ($urandom_range(0, 99) < 55) ? $urandom_range(1, 12)
					: $urandom_range(40, 250);
				fav = color_t'($urandom_range(COLOR_RED, COLOR_BLUE));
				alt = color_t'($urandom_range(COLOR_RED, COLOR_BLUE));
				split = $urandom_range(30, 75);
				for (int unsigned i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 15) begin
						hue = COLOR_NONE;
					end else begin
						hue = ($urandom_range(0, 99) < split) ? fav : alt;
					end
					px = make_pixel(hue, 1'b0);
					px.last = (i == len - 1);
					push_pixel(px, 1'b0, COLOR_NONE);
				end
			end
			phase++;
		end

		settle();
		if (mismatches == 0) begin
			$display("tb_dominant_color_pixel_vote: PASS");
		end else begin
			$display("tb_dominant_color_pixel_vote: FAIL");
		end
		$finish;
	end

endmodule
